>>> sv/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg: shared constants and types
// Constants and the per-stage control bundle used by the cubic Bezier point
// evaluator and its coordinate datapath.
// ----------------------------------------------------------------------------
package cbpe_pkg;

  localparam int STEPS_DEF      = 100;
  localparam int COORD_BITS_DEF = 16;

  localparam int IDX_W     = 7;
  localparam int IDX_DEPTH = 2 ** IDX_W;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_CTRL  = 4;
  localparam int NUM_AXES  = 3;

  localparam int FRAC     = 16;
  localparam int TW       = FRAC + 1;
  localparam int ONE_Q16  = 2 ** FRAC;
  localparam logic [TW-1:0] T_ONE = TW'(ONE_Q16);

  // one item register stage for t lookup, six in each coordinate lane
  localparam int NUM_STAGES  = 7;
  localparam int LANE_STAGES = NUM_STAGES - 1;

  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
    logic [TW-1:0]          t_s1;
    logic [TW-1:0]          t_s3;
    logic [TW-1:0]          t_s5;
  } stage_ctl_t;

endpackage

>>> sv/cbpe_lane.sv
// ----------------------------------------------------------------------------
// cbpe_lane: one coordinate of the curve point
// Power-basis coefficients, then a*t + b, *t + c, *t + d in six register
// stages, with exact products split to narrow multipliers and one rounding.
// ----------------------------------------------------------------------------
module cbpe_lane #(
  parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  cbpe_pkg::stage_ctl_t          ctl_i,
  input  logic signed [COORD_BITS-1:0]  p0_i,
  input  logic signed [COORD_BITS-1:0]  p1_i,
  input  logic signed [COORD_BITS-1:0]  p2_i,
  input  logic signed [COORD_BITS-1:0]  p3_i,
  output logic signed [COORD_BITS-1:0]  coord_o
);
  import cbpe_pkg::*;

  localparam int KW   = COORD_BITS + 5;
  localparam int PAW  = KW + TW + 1;
  localparam int S1W  = COORD_BITS + 21;
  localparam int M1HW = (S1W - FRAC) + TW + 1;
  localparam int MLW  = FRAC + TW;
  localparam int S2W  = COORD_BITS + 38;
  localparam int M2HW = (S2W - 2 * FRAC) + TW + 1;
  localparam int SUMW = COORD_BITS + 55;

  logic signed [KW-1:0]         p0e, p1e, p2e, p3e, dt, ut, vt;
  logic signed [KW-1:0]         a_d, b_d, c_d;
  logic signed [KW-1:0]         a_q, b_q, c_q;
  logic signed [COORD_BITS-1:0] d_q;

  logic signed [PAW-1:0]        pa_q;
  logic signed [S1W-1:0]        s1_d, s1_q;
  logic signed [M1HW-1:0]       m1h_q;
  logic        [MLW-1:0]        m1l_q;
  logic signed [S2W-1:0]        s2_d, s2_q;
  logic signed [M2HW-1:0]       m2h_q;
  logic        [MLW-1:0]        m2m_q, m2l_q;
  logic signed [SUMW-1:0]       sum_d;
  logic signed [COORD_BITS-1:0] coord_q;

  // a = -p0 + 3p1 - 3p2 + p3, b = 3(p0 - 2p1 + p2), c = 3(p1 - p0)
  always_comb begin
    p0e = KW'(p0_i);
    p1e = KW'(p1_i);
    p2e = KW'(p2_i);
    p3e = KW'(p3_i);
    dt  = p1e - p2e;
    ut  = p0e - (p1e <<< 1) + p2e;
    vt  = p1e - p0e;
    a_d = (p3e - p0e) + dt + (dt <<< 1);
    b_d = ut + (ut <<< 1);
    c_d = vt + (vt <<< 1);
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= p0_i;
  end

  always_comb begin
    s1_d = S1W'(pa_q) + (S1W'(b_q) <<< FRAC);
    s2_d = (S2W'(m1h_q) <<< FRAC) + $signed(S2W'(m1l_q)) + (S2W'(c_q) <<< (2 * FRAC));
    sum_d = (SUMW'(m2h_q) <<< (2 * FRAC))
          + ($signed(SUMW'(m2m_q)) <<< FRAC)
          + $signed(SUMW'(m2l_q))
          + (SUMW'(d_q) <<< (3 * FRAC))
          + (SUMW'(1) <<< (3 * FRAC - 1));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      pa_q <= a_q * $signed({1'b0, ctl_i.t_s1});
    end
    if (ctl_i.load[1]) begin
      s1_q <= s1_d;
    end
    if (ctl_i.load[2]) begin
      m1h_q <= $signed(s1_q[S1W-1:FRAC]) * $signed({1'b0, ctl_i.t_s3});
      m1l_q <= s1_q[FRAC-1:0] * ctl_i.t_s3;
    end
    if (ctl_i.load[3]) begin
      s2_q <= s2_d;
    end
    if (ctl_i.load[4]) begin
      m2h_q <= $signed(s2_q[S2W-1:2*FRAC]) * $signed({1'b0, ctl_i.t_s5});
      m2m_q <= s2_q[2*FRAC-1:FRAC] * ctl_i.t_s5;
      m2l_q <= s2_q[FRAC-1:0] * ctl_i.t_s5;
    end
    if (ctl_i.load[5]) begin
      coord_q <= sum_d[3*FRAC +: COORD_BITS];
    end
  end

  assign coord_o = coord_q;

endmodule

>>> sv/cubic_bezier_point_eval_top.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_top: cubic Bezier curve point evaluator
// Returns x, y, z of the curve point at t = k/STEPS for four control points.
// ----------------------------------------------------------------------------
// Usage:
//   Control points P0..P3 are written through the cfg channel (cfg_ready_o is
//   always high), index 0..3, x/y/z packed as signed COORD_BITS-bit lanes.
//   Write them only while no item is in flight.
//   Input items carry sample_index_i (k); k above STEPS acts as STEPS.
//   Each item gives one output item with point_x_o, point_y_o, point_z_o,
//   rounded to nearest, ties toward plus infinity.
//   There is one stage for the t lookup and six in each coordinate lane
//   (a*t, +b, split *t, +c, split *t, +d and round), all of them registered.
//   Throughput is one item per cycle while the receiver does not stall.
//   Stages advance independently, so bubbles close up; in_stall_o rises only
//   when all seven stages hold items and the receiver stalls.
//   Reset clears the control points to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_top #(
  parameter int STEPS      = cbpe_pkg::STEPS_DEF,
  parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cbpe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [3*COORD_BITS-1:0]            cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [cbpe_pkg::IDX_W-1:0]         sample_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [COORD_BITS-1:0]       point_x_o,
  output logic signed [COORD_BITS-1:0]       point_y_o,
  output logic signed [COORD_BITS-1:0]       point_z_o
);
  import cbpe_pkg::*;

  localparam int CFG_W = NUM_AXES * COORD_BITS;

  logic [NUM_CTRL-1:0][CFG_W-1:0]     cfg_q;
  logic [TW-1:0]                      t_lut [IDX_DEPTH];
  logic [NUM_STAGES-1:0]              v_q;
  logic [NUM_STAGES:0]                rdy;
  logic [TW-1:0]                      t_q [5];
  stage_ctl_t                         ctl;
  logic signed [COORD_BITS-1:0]       coord [NUM_AXES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // t = round(k * 2^16 / STEPS), k clamped to STEPS
  for (genvar g = 0; g < IDX_DEPTH; g++) begin : g_tlut
    localparam int KS = (g > STEPS) ? STEPS : g;
    localparam logic [TW-1:0] TV = TW'((KS * ONE_Q16 + STEPS / 2) / STEPS);
    assign t_lut[g] = TV;
  end

  always_comb begin
    rdy[NUM_STAGES] = !out_stall_i;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      t_q[0] <= t_lut[sample_index_i];
    end
    for (int i = 1; i < 5; i++) begin
      if (rdy[i]) begin
        t_q[i] <= t_q[i-1];
      end
    end
  end

  always_comb begin
    ctl.load = rdy[NUM_STAGES-1:1];
    ctl.t_s1 = t_q[0];
    ctl.t_s3 = t_q[2];
    ctl.t_s5 = t_q[4];
  end

  for (genvar j = 0; j < NUM_AXES; j++) begin : g_lane
    cbpe_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .p0_i    ($signed(cfg_q[0][j*COORD_BITS +: COORD_BITS])),
      .p1_i    ($signed(cfg_q[1][j*COORD_BITS +: COORD_BITS])),
      .p2_i    ($signed(cfg_q[2][j*COORD_BITS +: COORD_BITS])),
      .p3_i    ($signed(cfg_q[3][j*COORD_BITS +: COORD_BITS])),
      .coord_o (coord[j])
    );
  end

  assign point_x_o = coord[0];
  assign point_y_o = coord[1];
  assign point_z_o = coord[2];

`ifndef SYNTHESIS
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&v_q) && out_stall_i))
    else $error("input stalled while pipeline has room");

  a_t_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (t_q[0] <= T_ONE))
    else $error("t lookup beyond one");

  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (cfg_q[$past(cfg_index_i)] == $past(cfg_data_i)))
    else $error("control point write lost");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v_q[NUM_STAGES-2]) |=> !out_valid_o)
    else $error("output item repeated");
`endif

endmodule
